/* design/iee_pkg.sv */
// ----------------------------------------------------------------------------
// iee_pkg: shared types and constants for the infix expression evaluator
// Character classes, operator codes, status codes and default parameters.
// ----------------------------------------------------------------------------
package iee_pkg;

  localparam int STACK_DEPTH_DEF = 128;
  localparam int VALUE_WIDTH_DEF = 48;
  localparam int FRAC_BITS_DEF   = 16;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DIV0  = 2'd1;
  localparam logic [1:0] ST_OVF   = 2'd2;
  localparam logic [1:0] ST_STACK = 2'd3;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  typedef enum logic [1:0] {
    K_SKIP  = 2'd0,
    K_DIGIT = 2'd1,
    K_OPER  = 2'd2
  } kind_t;

  // classified item passed from front to back
  typedef struct packed {
    kind_t      kind;
    logic [3:0] digit;
    logic [1:0] op;
    logic       last;
  } token_t;

endpackage

/* design/infix_expression_evaluator_top.sv */
// ----------------------------------------------------------------------------
// infix_expression_evaluator_top: streaming infix arithmetic evaluator
// Characters in through a queue front end, two-stack evaluation in the back.
// ----------------------------------------------------------------------------
// Flow: an item waits in the front queue; the engine handles a digit or space
//   in S_FLUSH and an operator in S_FLUSH, S_RTOP, S_RTOPW and S_PUSHOP. Each
//   reduction pops an operator and two values and runs the ALU: add/sub,
//   multiply by 16-bit partial products, divide in the serial divider. The
//   last item adds its closing reductions; S_FINRD and S_FINW read the result.
// Throughput: the engine takes a new item only in S_IDLE; an operator or the
//   last item holds it for every reduction it triggers, and a waiting result
//   holds it until popped. The two-entry front queue accepts items meanwhile.
// Reset: synchronous rst empties both stacks, the queue and the result slot.
module infix_expression_evaluator_top #(
  parameter int STACK_DEPTH = iee_pkg::STACK_DEPTH_DEF,
  parameter int VALUE_WIDTH = iee_pkg::VALUE_WIDTH_DEF,
  parameter int FRAC_BITS   = iee_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    char_code,
  input  logic                          last_char,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [VALUE_WIDTH-1:0] result_value,
  output logic [1:0]                    status
);

  // tokens from the classifier to the engine
  logic            tok_valid;
  logic            tok_take;
  iee_pkg::token_t tok;

  iee_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .char_code(char_code), .last_char(last_char),
    .tok_valid(tok_valid), .tok(tok), .tok_take(tok_take));

  // back end: stacks, ALU and the result slot
  iee_back #(
    .STACK_DEPTH(STACK_DEPTH), .VALUE_WIDTH(VALUE_WIDTH), .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk(clk), .rst(rst), .tok_valid(tok_valid), .tok(tok), .tok_take(tok_take),
    .empty(empty), .pop(pop), .result_value(result_value), .status(status));

  // a token is only taken when one is waiting
  a_take: assert property (@(posedge clk) disable iff (rst) tok_take |-> tok_valid)
    else $error("token taken from empty queue");

  // a stack-overflow result always reads as the positive bound
  a_stk: assert property (@(posedge clk) disable iff (rst)
    (!empty && status == iee_pkg::ST_STACK) |->
      (result_value == {1'b0, {(VALUE_WIDTH-1){1'b1}}}))
    else $error("stack overflow result not saturated");

  // a waiting result holds until popped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result_value) && $stable(status)))
    else $error("result changed while waiting");

endmodule

/* design/iee_ram.sv */
// ----------------------------------------------------------------------------
// iee_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module iee_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* design/iee_front.sv */
// ----------------------------------------------------------------------------
// iee_front: classify characters and queue tokens
// Two-entry queue between the input handshake and the evaluation engine.
// ----------------------------------------------------------------------------
module iee_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        char_code,
  input  logic              last_char,
  output logic              tok_valid,
  output iee_pkg::token_t   tok,
  input  logic              tok_take
);

  iee_pkg::token_t q [2];
  logic [1:0]      cnt;
  iee_pkg::token_t t_in;
  logic            wr;
  logic            rd;

  always_comb begin
    t_in.digit = 4'(char_code - iee_pkg::CH_ZERO);
    t_in.last  = last_char;
    t_in.op    = iee_pkg::OP_ADD;
    t_in.kind  = iee_pkg::K_SKIP;
    if (char_code >= iee_pkg::CH_ZERO && char_code <= iee_pkg::CH_NINE) begin
      t_in.kind = iee_pkg::K_DIGIT;
    end else begin
      case (char_code)
        iee_pkg::CH_PLUS:  begin t_in.kind = iee_pkg::K_OPER; t_in.op = iee_pkg::OP_ADD; end
        iee_pkg::CH_MINUS: begin t_in.kind = iee_pkg::K_OPER; t_in.op = iee_pkg::OP_SUB; end
        iee_pkg::CH_STAR:  begin t_in.kind = iee_pkg::K_OPER; t_in.op = iee_pkg::OP_MUL; end
        iee_pkg::CH_SLASH: begin t_in.kind = iee_pkg::K_OPER; t_in.op = iee_pkg::OP_DIV; end
        default: ;
      endcase
    end
  end

  assign full      = (cnt == 2'd2);
  assign tok_valid = (cnt != 2'd0);
  assign tok       = q[0];
  assign wr        = push && !full;
  assign rd        = tok_take && tok_valid;

  always_ff @(posedge clk) begin
    if (rd) begin
      q[0] <= q[1];
    end
    if (wr) begin
      if (rd) begin
        if (cnt == 2'd1) q[0] <= t_in; else q[1] <= t_in;
      end else begin
        if (cnt == 2'd0) q[0] <= t_in; else q[1] <= t_in;
      end
    end
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + 2'(wr) - 2'(rd);
    end
  end

endmodule

/* design/iee_alu.sv */
// ----------------------------------------------------------------------------
// iee_alu: fixed-point arithmetic unit
// Add/sub in one step, multiply by 16-bit partial products, divide bit-serial.
// ----------------------------------------------------------------------------
module iee_alu #(
  parameter int VALUE_WIDTH = iee_pkg::VALUE_WIDTH_DEF,
  parameter int FRAC_BITS   = iee_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [1:0]                    op,
  input  logic signed [VALUE_WIDTH-1:0] x,
  input  logic signed [VALUE_WIDTH-1:0] y,
  output logic                          done,
  output logic signed [VALUE_WIDTH-1:0] res,
  output logic [1:0]                    err
);

  localparam int W   = VALUE_WIDTH;
  localparam int PW  = 2 * W + 2;
  localparam int NC  = (W + 15) / 16;
  localparam int DN  = W + FRAC_BITS;
  localparam int CW  = $clog2(DN + 1) + 1;
  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  typedef enum logic [2:0] { A_IDLE, A_MUL, A_DIV, A_FIN, A_DONE } astate_t;
  astate_t state;

  logic [W-1:0]   ma, mb;
  logic           neg;
  logic [PW-1:0]  acc;
  logic [CW-1:0]  cnt;
  logic [DN-1:0]  dvd;
  logic [W:0]     rem;
  logic [1:0]     opr;

  logic [W-1:0] xa, ya;
  assign xa = x[W-1] ? W'(-x) : W'(x);
  assign ya = y[W-1] ? W'(-y) : W'(y);

  logic signed [W+1:0] sum;
  assign sum = (op == iee_pkg::OP_ADD) ? ($signed({x[W-1], x[W-1], x}) + (W+2)'(y))
                                       : ($signed({x[W-1], x[W-1], x}) - (W+2)'(y));

  // multiply chunk: 16 bits of b times a
  logic [15:0]   chunk;
  logic [W+15:0] part;
  assign chunk = 16'(mb >> (16 * cnt));
  assign part  = (W+16)'(ma) * (W+16)'(chunk);

  logic [W:0] rsh;
  logic [W:0] rdiff;
  assign rsh   = {rem[W-1:0], dvd[DN-1]};
  assign rdiff = rsh - {1'b0, mb};

  // rounding and saturation of a magnitude held in acc
  logic [PW-1:0] rnd;
  logic          big;
  logic [W:0]    qm;
  always_comb begin
    rnd = acc;
    if (opr == iee_pkg::OP_MUL && FRAC_BITS > 0) begin
      rnd = (acc + (PW'(1) << (FRAC_BITS > 0 ? FRAC_BITS - 1 : 0))) >> FRAC_BITS;
    end else if (opr == iee_pkg::OP_DIV) begin
      rnd = acc + PW'({1'b0, rem} >= (W+1)'({1'b0, mb}) - (W+1)'(rem));
    end
    big = (rnd >> W) != 0;
    qm  = rnd[W:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        A_IDLE: begin
          if (start) begin
            opr <= op;
            neg <= x[W-1] ^ y[W-1];
            ma  <= xa;
            mb  <= ya;
            acc <= '0;
            cnt <= '0;
            rem <= '0;
            dvd <= DN'(xa) << FRAC_BITS;
            err <= iee_pkg::ST_OK;
            if (op == iee_pkg::OP_ADD || op == iee_pkg::OP_SUB) begin
              if (sum > $signed((W+2)'(VMAX))) begin
                res <= VMAX; err <= iee_pkg::ST_OVF;
              end else if (sum < $signed({2'b11, VMIN})) begin
                res <= VMIN; err <= iee_pkg::ST_OVF;
              end else begin
                res <= W'(sum);
              end
              state <= A_DONE;
            end else if (op == iee_pkg::OP_MUL) begin
              state <= A_MUL;
            end else if (y == '0) begin
              res   <= x[W-1] ? VMIN : VMAX;
              err   <= iee_pkg::ST_DIV0;
              state <= A_DONE;
            end else begin
              state <= A_DIV;
            end
          end
        end
        A_MUL: begin
          acc <= acc + (PW'(part) << (16 * cnt));
          cnt <= cnt + 1'b1;
          if (cnt == CW'(NC - 1)) state <= A_FIN;
        end
        A_DIV: begin
          dvd <= dvd << 1;
          if (!rdiff[W]) begin
            rem <= rdiff;
            acc <= (acc << 1) | PW'(1);
          end else begin
            rem <= rsh;
            acc <= acc << 1;
          end
          cnt <= cnt + 1'b1;
          if (cnt == CW'(DN - 1)) state <= A_FIN;
        end
        A_FIN: begin
          if (big || qm > ((W+1)'(VMAX) + (W+1)'(neg))) begin
            res <= neg ? VMIN : VMAX;
            err <= iee_pkg::ST_OVF;
          end else begin
            res <= neg ? W'(-qm) : W'(qm);
          end
          state <= A_DONE;
        end
        A_DONE: begin
          done  <= 1'b1;
          state <= A_IDLE;
        end
        default: state <= A_IDLE;
      endcase
    end
  end

endmodule

/* design/iee_back.sv */
// ----------------------------------------------------------------------------
// iee_back: two-stack evaluation sequencer
// Takes tokens, drives the stack RAMs and the ALU, and posts the result.
// ----------------------------------------------------------------------------
module iee_back #(
  parameter int STACK_DEPTH = iee_pkg::STACK_DEPTH_DEF,
  parameter int VALUE_WIDTH = iee_pkg::VALUE_WIDTH_DEF,
  parameter int FRAC_BITS   = iee_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          tok_valid,
  input  iee_pkg::token_t               tok,
  output logic                          tok_take,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [VALUE_WIDTH-1:0] result_value,
  output logic [1:0]                    status
);

  localparam int W  = VALUE_WIDTH;
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};

  typedef enum logic [3:0] {
    S_IDLE, S_FLUSH, S_RTOP, S_RTOPW, S_PY, S_PYW, S_PX, S_PXW, S_ALU,
    S_PUSHOP, S_FINRD, S_FINW, S_OUT
  } bstate_t;
  bstate_t state;

  iee_pkg::token_t cur;
  logic [CW-1:0]   vcnt, ocnt;
  logic [W-1:0]    accum;
  logic            in_num;
  logic [1:0]      errs;
  logic [1:0]      lvl;
  logic [1:0]      rop;
  logic [W-1:0]    yv, xv;
  logic            finishing;

  logic          v_we, o_we;
  logic [AW-1:0] v_addr, o_addr;
  logic [W-1:0]  v_wd, v_rd;
  logic [1:0]    o_wd, o_rd;

  logic          alu_start, alu_done;
  logic [W-1:0]  alu_res;
  logic [1:0]    alu_err;

  iee_ram #(.WIDTH(W), .DEPTH(STACK_DEPTH)) u_vstack (
    .clk(clk), .we(v_we), .addr(v_addr), .wdata(v_wd), .rdata(v_rd));
  iee_ram #(.WIDTH(2), .DEPTH(STACK_DEPTH)) u_ostack (
    .clk(clk), .we(o_we), .addr(o_addr), .wdata(o_wd), .rdata(o_rd));

  iee_alu #(.VALUE_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_alu (
    .clk(clk), .rst(rst), .start(alu_start), .op(rop), .x(xv), .y(yv),
    .done(alu_done), .res(alu_res), .err(alu_err));

  // digit step: acc*10 + d<<F with overflow check
  logic [W+4:0] d_sh;
  logic [W+4:0] acc10;
  assign d_sh  = (W+5)'(cur.digit) << FRAC_BITS;
  assign acc10 = ((W+5)'(accum) << 3) + ((W+5)'(accum) << 1) + d_sh;

  function automatic logic [1:0] first_err(input logic [1:0] e, input logic [1:0] n);
    first_err = (e == iee_pkg::ST_OK) ? n : e;
  endfunction

  logic [1:0] prec_top;
  assign prec_top = (o_rd >= iee_pkg::OP_MUL) ? 2'd3 : 2'd2;

  assign tok_take  = (state == S_IDLE) && tok_valid;
  assign empty     = (state != S_OUT);
  assign alu_start = (state == S_ALU) && !alu_done;

  always_comb begin
    v_we   = 1'b0;
    v_wd   = accum;
    v_addr = AW'(vcnt);
    o_we   = 1'b0;
    o_wd   = cur.op;
    o_addr = AW'(ocnt - 1'b1);
    unique case (state)
      S_FLUSH: begin
        v_we = in_num && (vcnt < CW'(STACK_DEPTH));
      end
      S_PY: v_addr = AW'(vcnt - 1'b1);
      S_PX: v_addr = AW'(vcnt - 1'b1);
      S_ALU: begin
        v_wd = alu_res;
        v_we = alu_done && (vcnt < CW'(STACK_DEPTH));
      end
      S_PUSHOP: begin
        o_addr = AW'(ocnt);
        o_we   = (ocnt < CW'(STACK_DEPTH));
      end
      S_FINRD: v_addr = AW'(vcnt - 1'b1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      vcnt   <= '0;
      ocnt   <= '0;
      accum  <= '0;
      in_num <= 1'b0;
      errs   <= iee_pkg::ST_OK;
      finishing <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          finishing <= 1'b0;
          if (tok_valid) begin
            cur <= tok;
            if (tok.kind == iee_pkg::K_DIGIT) begin
              state <= S_FLUSH;
            end else begin
              state <= S_FLUSH;
            end
          end
        end
        S_FLUSH: begin
          if (cur.kind == iee_pkg::K_DIGIT && !finishing) begin
            if (acc10 > (W+5)'(VMAX)) begin
              errs  <= first_err(errs, iee_pkg::ST_OVF);
              accum <= VMAX;
            end else begin
              accum <= W'(acc10);
            end
            in_num <= 1'b1;
            if (cur.last) begin
              finishing <= 1'b1;
              state     <= S_FLUSH;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            if (in_num) begin
              if (vcnt < CW'(STACK_DEPTH)) vcnt <= vcnt + 1'b1;
              else errs <= first_err(errs, iee_pkg::ST_STACK);
              accum  <= '0;
              in_num <= 1'b0;
            end
            if (cur.kind == iee_pkg::K_OPER && !finishing) begin
              lvl   <= (cur.op >= iee_pkg::OP_MUL) ? 2'd3 : 2'd2;
              state <= S_RTOP;
            end else if (cur.last) begin
              finishing <= 1'b1;
              lvl   <= 2'd1;
              state <= S_RTOP;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_RTOP: state <= S_RTOPW;
        S_RTOPW: begin
          if (ocnt != '0 && prec_top >= lvl) begin
            rop   <= o_rd;
            ocnt  <= ocnt - 1'b1;
            state <= S_PY;
          end else if (finishing) begin
            state <= S_FINRD;
          end else begin
            state <= S_PUSHOP;
          end
        end
        S_PY: state <= S_PYW;
        S_PYW: begin
          yv <= (vcnt != '0) ? v_rd : '0;
          if (vcnt != '0) vcnt <= vcnt - 1'b1;
          state <= S_PX;
        end
        S_PX: state <= S_PXW;
        S_PXW: begin
          xv <= (vcnt != '0) ? v_rd : '0;
          if (vcnt != '0) vcnt <= vcnt - 1'b1;
          state <= S_ALU;
        end
        S_ALU: begin
          if (alu_done) begin
            if (alu_err != iee_pkg::ST_OK) errs <= first_err(errs, alu_err);
            if (vcnt < CW'(STACK_DEPTH)) vcnt <= vcnt + 1'b1;
            else errs <= first_err(first_err(errs, alu_err), iee_pkg::ST_STACK);
            state <= S_RTOP;
          end
        end
        S_PUSHOP: begin
          if (ocnt < CW'(STACK_DEPTH)) ocnt <= ocnt + 1'b1;
          else errs <= first_err(errs, iee_pkg::ST_STACK);
          if (cur.last) begin
            finishing <= 1'b1;
            lvl   <= 2'd1;
            state <= S_RTOP;
          end else begin
            state <= S_IDLE;
          end
        end
        S_FINRD: state <= S_FINW;
        S_FINW: begin
          result_value <= (errs == iee_pkg::ST_STACK) ? VMAX :
                          (vcnt != '0) ? v_rd : '0;
          status <= errs;
          vcnt   <= '0;
          ocnt   <= '0;
          accum  <= '0;
          in_num <= 1'b0;
          errs   <= iee_pkg::ST_OK;
          state  <= S_OUT;
        end
        S_OUT: begin
          if (pop) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
